/* design/ame_pkg.sv */
package ame_pkg;

    localparam int DATA_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int CID_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COMPANY_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AD_TYPE    = 1'b1;

    localparam logic [CID_W-1:0]  COMPANY_ID_RST = 16'hBABE;
    localparam logic [DATA_W-1:0] AD_TYPE_RST    = 8'hFF;

    // shortest structure that can carry type and identifier
    localparam logic [DATA_W-1:0] MIN_MATCH_LEN = 8'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_PAYLOAD = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC   = 2'd2;

    typedef enum logic [5:0] {
        PH_LEN  = 6'b000001,
        PH_TYPE = 6'b000010,
        PH_IDLO = 6'b000100,
        PH_IDHI = 6'b001000,
        PH_BODY = 6'b010000,
        PH_DONE = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [CID_W-1:0]  company_id;
        logic [DATA_W-1:0] ad_type;
    } t_cfg;

    typedef struct packed {
        logic                emit;
        logic [DATA_W-1:0]   payload_byte;
        logic                payload_end;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

/* design/ame_in_if.sv */
interface ame_in_if;
    logic                         valid;
    logic                         ready;
    logic [ame_pkg::DATA_W-1:0]   data_byte;
    logic                         record_end;

    modport source (output valid, output data_byte, output record_end, input ready);
    modport sink   (input valid, input data_byte, input record_end, output ready);
endinterface

/* design/ame_out_if.sv */
interface ame_out_if;
    logic                         valid;
    logic                         ready;
    logic [ame_pkg::DATA_W-1:0]   payload_byte;
    logic                         payload_end;
    logic [ame_pkg::STATUS_W-1:0] status;

    modport source (output valid, output payload_byte, output payload_end, output status,
                    input ready);
    modport sink   (input valid, input payload_byte, input payload_end, input status,
                    output ready);
endinterface

/* design/ame_cfg_if.sv */
interface ame_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ame_pkg::CFG_IDX_W-1:0] index;
    logic [ame_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/adv_manufacturer_data_extractor.sv */
// channel   dir  fields                                   word moves when
// i_in      in   data_byte[7:0], record_end               valid & ready
// o_out     out  payload_byte[7:0], payload_end, status   valid & ready
// i_cfg     in   index (0 company_id, 1 ad_type), data    valid & ready
//
// one word per cycle sustained while the result is not stalled: a word is held
// in the input register, is parsed by the structure walker and lands in the
// result register
// synchronous active-low reset: walker to length byte, registers to defaults
// a stalled result holds; the held input word waits behind it, so input stops
module adv_manufacturer_data_extractor (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ame_in_if.sink    i_in,
    ame_out_if.source o_out,
    ame_cfg_if.sink   i_cfg
);
    import ame_pkg::*;

    // input register stage
    logic              r_in_valid;
    logic [DATA_W-1:0] r_in_byte;
    logic              r_in_last;

    // result register stage
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_byte;
    logic                r_out_end;
    logic [STATUS_W-1:0] r_out_status;

    logic    out_free;
    logic    step;
    logic    in_take;
    t_cfg    cfg;
    t_result res;

    // result slot can be loaded when empty or being drained this cycle
    assign out_free = !r_out_valid || o_out.ready;
    // parse the held word whenever its result (if any) has a place to go
    assign step     = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || step;
    assign in_take  = i_in.valid && i_in.ready;

    // config writes are always taken
    assign i_cfg.ready = 1'b1;

    ame_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    ame_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.record_end;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.emit) begin
            r_out_byte   <= res.payload_byte;
            r_out_end    <= res.payload_end;
            r_out_status <= res.status;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.payload_byte = r_out_byte;
    assign o_out.payload_end  = r_out_end;
    assign o_out.status       = r_out_status;

    // closing statuses always end the record's results
    a_close_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_NONE || r_out_status == ST_TRUNC))
            |-> r_out_end)
        else $error("closing status without payload_end");

    // no-payload result carries a zero byte
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_NONE) |-> (r_out_byte == '0))
        else $error("no-payload result with nonzero byte");

    // a held word is not dropped while the result slot is stalled
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |=> r_in_valid)
        else $error("input word lost during output stall");

endmodule

/* design/ame_cfg_regs.sv */
module ame_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [ame_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [ame_pkg::CFG_DAT_W-1:0] i_data,
    output ame_pkg::t_cfg                 o_cfg
);
    import ame_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.company_id <= COMPANY_ID_RST;
            r_cfg.ad_type    <= AD_TYPE_RST;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_COMPANY_ID: r_cfg.company_id <= i_data[CID_W-1:0];
                CFG_AD_TYPE:    r_cfg.ad_type    <= i_data[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/ame_parser.sv */
module ame_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [ame_pkg::DATA_W-1:0] i_byte,
    input  logic                       i_last,
    input  ame_pkg::t_cfg              i_cfg,
    output ame_pkg::t_result           o_res
);
    import ame_pkg::*;

    t_phase            r_phase, n_phase;
    logic [DATA_W-1:0] r_left,  n_left;
    logic              r_cand,  n_cand;
    logic              r_found, n_found;
    logic [DATA_W-1:0] left_dec;
    logic              cand_new;
    t_result           res;

    assign left_dec = r_left - 1'b1;

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_cand   = r_cand;
        n_found  = r_found;
        cand_new = 1'b0;
        res      = '0;

        unique case (r_phase)
            PH_LEN: begin
                n_left  = i_byte;
                n_cand  = 1'b0;
                n_phase = (i_byte == '0) ? PH_LEN : PH_TYPE;
            end
            PH_TYPE, PH_IDLO, PH_IDHI: begin
                if (r_phase == PH_TYPE) begin
                    cand_new = (i_byte == i_cfg.ad_type) && (r_left >= MIN_MATCH_LEN);
                end else if (r_phase == PH_IDLO) begin
                    cand_new = r_cand && (i_byte == i_cfg.company_id[7:0]);
                end else begin
                    cand_new = r_cand && (i_byte == i_cfg.company_id[15:8]);
                end
                n_cand = cand_new;
                n_left = left_dec;
                if (r_phase == PH_IDHI && cand_new) begin
                    n_phase = (left_dec == '0) ? PH_DONE : PH_BODY;
                end else if (left_dec == '0) begin
                    n_phase = PH_LEN;
                end else if (r_phase == PH_TYPE) begin
                    n_phase = PH_IDLO;
                end else if (r_phase == PH_IDLO) begin
                    n_phase = PH_IDHI;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                n_left = left_dec;
                if (r_cand) begin
                    res.emit         = 1'b1;
                    res.payload_byte = i_byte;
                    res.status       = ST_PAYLOAD;
                    n_found          = 1'b1;
                    if (left_dec == '0) begin
                        res.payload_end = 1'b1;
                        n_phase         = PH_DONE;
                    end else if (i_last) begin
                        res.payload_end = 1'b1;
                        res.status      = ST_TRUNC;
                    end
                end else if (left_dec == '0) begin
                    n_phase = PH_LEN;
                end
            end
            PH_DONE: ;
            default: n_phase = PH_DONE;
        endcase

        // record closes with nothing sent
        if (i_last && !res.emit && !r_found) begin
            res.emit         = 1'b1;
            res.payload_byte = '0;
            res.payload_end  = 1'b1;
            res.status       = ST_NONE;
        end
        if (i_last) begin
            n_phase = PH_LEN;
            n_left  = '0;
            n_cand  = 1'b0;
            n_found = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN;
            r_left  <= '0;
            r_cand  <= 1'b0;
            r_found <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_cand  <= n_cand;
            r_found <= n_found;
        end
    end

    assign o_res = res;

endmodule
